FILE: rtl/core/bjd_pkg.sv
package bjd_pkg;

  localparam int BAND_W = 3;
  localparam int THR_W = 16;
  localparam int CNT_OUT_W = 16;
  localparam int DIST_W = 17;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd32768;

  localparam logic [BAND_W-1:0] BAND_IDENTICAL = 3'd0;
  localparam logic [BAND_W-1:0] BAND_AT_OR_BELOW = 3'd1;
  localparam logic [BAND_W-1:0] BAND_ABOVE = 3'd2;
  localparam logic [BAND_W-1:0] BAND_DISSIMILAR = 3'd3;
  localparam logic [BAND_W-1:0] BAND_UNDEFINED = 3'd4;

  typedef struct packed {
    logic bit_first;
    logic bit_second;
    logic last_position;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]    distance;
    logic [BAND_W-1:0]    band;
    logic [CNT_OUT_W-1:0] both_ones;
    logic [CNT_OUT_W-1:0] first_only;
    logic [CNT_OUT_W-1:0] second_only;
    logic                 count_overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_FIN
  } bjd_state_t;

  typedef struct packed {
    logic count_en;
    logic setup;
    logic div_step;
    logic div_first;
    logic emit;
  } bjd_cmd_t;

  typedef struct packed {
    logic out_busy;
  } bjd_sts_t;

endpackage

FILE: rtl/core/bjd_ctrl.sv
module bjd_ctrl
  import bjd_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  input  bjd_sts_t sts,
  output logic     in_ready,
  output bjd_cmd_t cmd
);

  localparam int SW = $clog2(FRACTION_BITS + 1);

  bjd_state_t    state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.count_en = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one quotient bit per cycle, FRACTION_BITS + 1 bits in all
        cmd.div_step  = 1'b1;
        cmd.div_first = (step_r == '0);
        step_nxt      = step_r + SW'(1);
        if (step_r == SW'(FRACTION_BITS)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/bjd_dp.sv
module bjd_dp
  import bjd_pkg::*;
#(
  parameter int MAX_COUNT     = 65535,
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  input  bjd_cmd_t         cmd,
  output bjd_sts_t         sts,
  input  logic             out_ready,
  output logic             out_valid,
  output out_item_t        out_item
);

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int MW = CW + 1;
  localparam int UW = CW + 2;
  localparam int RW = UW + 1;
  localparam int QW = FRACTION_BITS + 1;
  localparam int PW = UW + THR_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_COUNT);

  logic [THR_W-1:0] thr_r;

  logic [CW-1:0] both_r, first_r, second_r;
  logic [CW-1:0] both_nxt, first_nxt, second_nxt;
  logic          ovf_r, ovf_nxt;

  logic [CW-1:0] snap_both_r, snap_first_r, snap_second_r;
  logic          snap_ovf_r;

  logic [MW-1:0] mism_sum, mism_r;
  logic [UW-1:0] uni_sum, uni_r;
  logic [RW-1:0] rem_r, trial;
  logic          ge;
  logic [QW-1:0] q_r;
  logic [PW-1:0] prod_r;

  logic [QW+DIST_W-1:0]    q_ext;
  logic [CW+CNT_OUT_W-1:0] both_ext, first_ext, second_ext;
  logic [DIST_W-1:0]       dist_val;
  logic [BAND_W-1:0]       band;

  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // saturating tallies
  always_comb begin
    both_nxt   = both_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    ovf_nxt    = ovf_r;
    if (cmd.count_en) begin
      if (in_item.bit_first && in_item.bit_second) begin
        if (both_r == CNT_MAX) ovf_nxt = 1'b1;
        else both_nxt = both_r + CW'(1);
      end else if (in_item.bit_first) begin
        if (first_r == CNT_MAX) ovf_nxt = 1'b1;
        else first_nxt = first_r + CW'(1);
      end else if (in_item.bit_second) begin
        if (second_r == CNT_MAX) ovf_nxt = 1'b1;
        else second_nxt = second_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      both_r   <= '0;
      first_r  <= '0;
      second_r <= '0;
      ovf_r    <= 1'b0;
    end else if (cmd.count_en && in_item.last_position) begin
      both_r   <= '0;
      first_r  <= '0;
      second_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      both_r   <= both_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.count_en && in_item.last_position) begin
      snap_both_r   <= both_nxt;
      snap_first_r  <= first_nxt;
      snap_second_r <= second_nxt;
      snap_ovf_r    <= ovf_nxt;
    end
  end

  assign mism_sum = {1'b0, snap_first_r} + {1'b0, snap_second_r};
  assign uni_sum  = {1'b0, mism_sum} + {2'b00, snap_both_r};

  // restoring division, first step compares without a shift
  assign trial = cmd.div_first ? rem_r : {rem_r[RW-2:0], 1'b0};
  assign ge    = (trial >= {1'b0, uni_r});

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      mism_r <= mism_sum;
      uni_r  <= uni_sum;
      rem_r  <= {2'b00, mism_sum};
      q_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? (trial - {1'b0, uni_r}) : trial;
      q_r    <= {q_r[QW-2:0], ge};
      prod_r <= PW'(thr_r) * PW'(uni_r);
    end
  end

  assign q_ext      = {{DIST_W{1'b0}}, q_r};
  assign both_ext   = {{CNT_OUT_W{1'b0}}, snap_both_r};
  assign first_ext  = {{CNT_OUT_W{1'b0}}, snap_first_r};
  assign second_ext = {{CNT_OUT_W{1'b0}}, snap_second_r};

  always_comb begin
    dist_val = q_ext[DIST_W-1:0];
    if (uni_r == '0) begin
      band     = BAND_UNDEFINED;
      dist_val = '0;
    end else if (mism_r == '0) begin
      band = BAND_IDENTICAL;
    end else if ({1'b0, mism_r} == uni_r) begin
      band = BAND_DISSIMILAR;
    end else if ({1'b0, mism_r, {THR_W{1'b0}}} <= prod_r) begin
      band = BAND_AT_OR_BELOW;
    end else begin
      band = BAND_ABOVE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.distance       <= dist_val;
      out_item_r.band           <= band;
      out_item_r.both_ones      <= both_ext[CNT_OUT_W-1:0];
      out_item_r.first_only     <= first_ext[CNT_OUT_W-1:0];
      out_item_r.second_only    <= second_ext[CNT_OUT_W-1:0];
      out_item_r.count_overflow <= snap_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

`ifndef ASSERT_OFF
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.band == BAND_UNDEFINED) |->
      (out_item_r.distance == '0 && out_item_r.both_ones == '0 &&
       out_item_r.first_only == '0 && out_item_r.second_only == '0))
    else $error("undefined band with nonzero distance or counts");

  a_ident_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.band == BAND_IDENTICAL) |->
      (out_item_r.distance == '0 && out_item_r.first_only == '0 &&
       out_item_r.second_only == '0))
    else $error("identical band with mismatches");

  a_dissim_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.band == BAND_DISSIMILAR) |-> (out_item_r.both_ones == '0))
    else $error("fully dissimilar band with shared ones");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.div_step) && uni_r != '0) |-> (rem_r < {1'b0, uni_r}))
    else $error("division remainder not below divisor");
`endif

endmodule

FILE: rtl/core/binary_jaccard_distance_top.sv
// binary jaccard distance over a stream of bit pairs
// in_valid/in_ready/in_item: one request per bit position (bit_first,
//   bit_second, last_position); non-final positions are taken one per cycle
// cfg_we/cfg_wdata: writes band_threshold (Q0.16), reset value one half
// out_valid/out_ready/out_item: one result per vector pair, on the final
//   position: distance, band, the three tallies and the saturation flag
// after the final request is taken, a setup state, the bit-serial divider
//   and a finish state that loads the output register once it is free
//   follow in order; the restoring divider holds in_ready low while it
//   runs; no new pair is taken until the result is loaded
// the output register frees the input: a new pair streams in while the
//   previous result waits; if the receiver stalls, the next division
//   finishes and then waits until the output register is taken
// reset (rst_n low, synchronous) clears the tallies, drops out_valid and
//   sets the threshold back to one half
module binary_jaccard_distance_top
  import bjd_pkg::*;
#(
  parameter int MAX_COUNT     = 65535,
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  bjd_cmd_t cmd;
  bjd_sts_t sts;

  bjd_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_last (in_item.last_position),
    .sts     (sts),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  bjd_dp #(
    .MAX_COUNT    (MAX_COUNT),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule
